// ===== design/brd_pkg.sv =====
package brd_pkg;

    localparam int START_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int WORKERS_W = 7;
    localparam int INDEX_W   = 6;
    localparam int PSTART_W  = 34;
    localparam int PCOUNT_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;

    localparam int DEFAULT_MAX_WORKERS = 64;
    localparam int DEFAULT_COUNT_BITS  = 32;

    localparam logic [MODE_W-1:0] MODE_UNDEF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPLICATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MODE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/brd_in_if.sv =====
interface brd_in_if;
    import brd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [START_W-1:0]  range_start;
    logic [COUNT_W-1:0]         range_count;
    logic [WORKERS_W-1:0]       worker_count;

    modport source (output valid, output range_start, output range_count,
                    output worker_count, input ready);
    modport sink   (input valid, input range_start, input range_count,
                    input worker_count, output ready);
endinterface

// ===== design/brd_out_if.sv =====
interface brd_out_if;
    import brd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [INDEX_W-1:0]         worker_index;
    logic signed [PSTART_W-1:0] part_start;
    logic [PCOUNT_W-1:0]        part_count;
    logic                       last;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output worker_index, output part_start,
                    output part_count, output last, output status, input ready);
    modport sink   (input valid, input worker_index, input part_start,
                    input part_count, input last, input status, output ready);
endinterface

// ===== design/brd_cfg_if.sv =====
interface brd_cfg_if;
    import brd_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  format_mode;

    modport source (output valid, output format_mode, input ready);
    modport sink   (input valid, input format_mode, output ready);
endinterface

// ===== design/block_range_distributor.sv =====
// Channel   | Dir | Payload                                              | Handshake
// ----------+-----+------------------------------------------------------+-----------
// range_ch  | in  | range_start, range_count, worker_count               | valid/ready
// part_ch   | out | worker_index, part_start, part_count, last, status   | valid/ready
// cfg       | in  | format_mode                                          | valid/ready
//
// One request at a time. After accept, one result per worker per cycle from the
// output register while the output is not stalled. Block split with count >= workers
// first runs the bit-serial divider; an error request gives one result.
// Reset clears control and the mode register. Output stalls hold the worker walk.
module block_range_distributor #(
    parameter int MAX_WORKERS = brd_pkg::DEFAULT_MAX_WORKERS,
    parameter int COUNT_BITS  = brd_pkg::DEFAULT_COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    brd_in_if.sink        range_ch,
    brd_out_if.source     part_ch,
    brd_cfg_if.sink       cfg
);
    import brd_pkg::*;

    localparam int CW  = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam int WCW = $clog2(MAX_WORKERS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_EMIT = 4'b0100,
        S_ERR  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        K_REPL  = 2'd0,
        K_SMALL = 2'd1,
        K_BLOCK = 2'd2
    } kind_t;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [START_W-1:0]  start_reg, start_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [WCW-1:0]      workers_reg, workers_next;
    logic [WCW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]       bound_reg, bound_next;
    logic [WCW-1:0]      acc_reg, acc_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    // Divider runs once per request: hold a flag so it is not relaunched.
    logic                div_launched_reg, div_launched_next;

    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     out_index_reg, out_index_next;
    logic [PSTART_W-1:0]    out_start_reg, out_start_next;
    logic [PCOUNT_W-1:0]    out_count_reg, out_count_next;
    logic                   out_last_reg, out_last_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic                   accept;
    logic                   slot_free;
    logic [CW-1:0]          cnt_in;
    logic [WCW-1:0]         wsat;
    logic                   div_start;
    logic [CW-1:0]          quo;
    logic [WCW-1:0]         rem;
    div_stat_t              div_stat;
    logic [WCW:0]           acc_sum;
    logic                   carry;
    logic [CW-1:0]          lo;
    logic [CW-1:0]          n;
    logic                   is_last;
    logic [PSTART_W-1:0]    start_ext;

    assign range_ch.ready = state_reg[0];
    assign cfg.ready      = 1'b1;
    assign accept         = range_ch.valid && range_ch.ready;
    assign slot_free      = !out_valid_reg || part_ch.ready;

    assign cnt_in = range_ch.range_count[CW-1:0];
    assign wsat   = (range_ch.worker_count > WORKERS_W'(MAX_WORKERS))
                  ? WCW'(MAX_WORKERS) : WCW'(range_ch.worker_count);

    brd_divider #(
        .DIVIDEND_W (CW),
        .DIVISOR_W  (WCW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (count_reg),
        .divisor   (workers_reg),
        .quotient  (quo),
        .remainder (rem),
        .stat      (div_stat)
    );

    // Remainder accumulator steps floor(i*count/workers) without a multiply.
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, rem};
    assign carry     = (acc_sum >= {1'b0, workers_reg});
    assign is_last   = ((idx_reg + WCW'(1)) == workers_reg);
    assign start_ext = {{(PSTART_W-START_W){start_reg[START_W-1]}}, start_reg};

    always_comb
    begin
        unique case (kind_reg)
            K_REPL:
            begin
                lo = '0;
                n  = count_reg;
            end
            K_SMALL:
            begin
                lo = (CW'(idx_reg) < count_reg) ? CW'(idx_reg) : '0;
                n  = (CW'(idx_reg) < count_reg) ? CW'(1) : '0;
            end
            K_BLOCK:
            begin
                lo = bound_reg;
                n  = quo + CW'(carry);
            end
            default:
            begin
                lo = '0;
                n  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        workers_next    = workers_reg;
        idx_next        = idx_reg;
        bound_next      = bound_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        div_start       = 1'b0;
        out_valid_next  = out_valid_reg && !part_ch.ready;
        out_index_next  = out_index_reg;
        out_start_next  = out_start_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    start_next   = range_ch.range_start;
                    count_next   = cnt_in;
                    workers_next = wsat;
                    idx_next     = '0;
                    bound_next   = '0;
                    acc_next     = '0;
                    priority if (cnt_in == '0 || range_ch.worker_count == '0)
                    begin
                        err_next   = STATUS_ZERO;
                        state_next = S_ERR;
                    end
                    else if (mode_reg == MODE_REPLICATE)
                    begin
                        kind_next  = K_REPL;
                        state_next = S_EMIT;
                    end
                    else if (mode_reg == MODE_BLOCK)
                    begin
                        if (cnt_in < CW'(wsat))
                        begin
                            kind_next  = K_SMALL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            kind_next  = K_BLOCK;
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        err_next   = STATUS_MODE;
                        state_next = S_ERR;
                    end
                end
            end
            S_DIV:
            begin
                // launch on entry, wait for the last quotient bit
                div_start = !div_stat.busy && !div_stat.done && !div_launched_reg;
                if (div_stat.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = INDEX_W'(idx_reg);
                    out_start_next  = start_ext + PSTART_W'(lo);
                    out_count_next  = PCOUNT_W'(n);
                    out_last_next   = is_last;
                    out_status_next = STATUS_OK;
                    idx_next        = idx_reg + WCW'(1);
                    bound_next      = CW'(bound_reg + quo + CW'(carry));
                    acc_next        = carry ? WCW'(acc_sum - {1'b0, workers_reg})
                                            : WCW'(acc_sum);
                    if (is_last)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = '0;
                    out_start_next  = '0;
                    out_count_next  = '0;
                    out_last_next   = 1'b1;
                    out_status_next = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_launched_next = div_launched_reg;
        if (accept)
            div_launched_next = 1'b0;
        else if (div_start)
            div_launched_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mode_reg         <= MODE_UNDEF;
            out_valid_reg    <= 1'b0;
            div_launched_reg <= 1'b0;
            kind_reg         <= K_REPL;
            idx_reg          <= '0;
            workers_reg      <= '0;
            acc_reg          <= '0;
            err_reg          <= STATUS_OK;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            div_launched_reg <= div_launched_next;
            kind_reg         <= kind_next;
            idx_reg          <= idx_next;
            workers_reg      <= workers_next;
            acc_reg          <= acc_next;
            err_reg          <= err_next;
            if (cfg.valid && cfg.ready)
                mode_reg <= cfg.format_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        count_reg      <= count_next;
        bound_reg      <= bound_next;
        out_index_reg  <= out_index_next;
        out_start_reg  <= out_start_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign part_ch.valid        = out_valid_reg;
    assign part_ch.worker_index = out_index_reg;
    assign part_ch.part_start   = out_start_reg;
    assign part_ch.part_count   = out_count_reg;
    assign part_ch.last         = out_last_reg;
    assign part_ch.status       = out_status_reg;

endmodule

// ===== design/brd_divider.sv =====
// Restoring divider: one quotient bit per cycle, dividend shifted out MSB first.
module brd_divider #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [DIVISOR_W-1:0]          divisor,
    output logic [DIVIDEND_W-1:0]         quotient,
    output logic [DIVISOR_W-1:0]          remainder,
    output brd_pkg::div_stat_t            stat
);
    import brd_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : DIVISOR_W'(trial);
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
